[src/pgbf_pkg.sv]
// ----------------------------------------------------------------------------
// pgbf_pkg: shared definitions for the periodic grid bilinear field core
// Grid sizes, pipeline depths, register indexes, payload types and the small
// helper functions that the locate, grid and interpolation stages share.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pgbf_pkg;

  // Grid store dimensions.
  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 128;
  localparam int AXIS_MAX = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  // Width that holds a grid size from 1 up to AXIS_MAX.
  localparam int N_W      = $clog2(AXIS_MAX + 1);

  // Fixed point and cell-index arithmetic.
  localparam int FRAC_W     = 16;
  localparam int IP_W       = 33;
  localparam int MOD_STEP   = 7;
  localparam int MOD_STAGES = (IP_W + MOD_STEP - 1) / MOD_STEP;
  localparam int DIV_W      = MOD_STAGES * MOD_STEP;

  // Pipeline depths: locate front end, remainder stages, wrap stages.
  localparam int LOC_LAT    = 7 + MOD_STAGES;
  localparam int INTERP_LAT = 7;
  localparam int TOTAL_LAT  = LOC_LAT + 1 + INTERP_LAT;

  // Corners of a cell: corner, right, up, up-right.
  localparam int NUM_CORNERS = 4;
  localparam int C00 = 0;
  localparam int C10 = 1;
  localparam int C01 = 2;
  localparam int C11 = 3;
  localparam bit CORNER_DX [NUM_CORNERS] = '{1'b0, 1'b1, 1'b0, 1'b1};
  localparam bit CORNER_DY [NUM_CORNERS] = '{1'b0, 1'b0, 1'b1, 1'b1};

  localparam int CFG_IDX_W = 3;

  typedef logic signed [31:0] word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLS = 3'd0,
    REG_GRID_ROWS = 3'd1,
    REG_X_ORIGIN  = 3'd2,
    REG_Y_ORIGIN  = 3'd3,
    REG_X_CPU     = 3'd4,
    REG_Y_CPU     = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  // One grid write travelling down the pipeline.
  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    word_t            value;
  } grid_wr_t;

  // One result item.
  typedef struct packed {
    word_t potential;
    word_t force_x;
    word_t force_y;
    logic  saturated;
  } result_t;

  // Effective grid size: zero acts as one, oversize acts as the store size.
  function automatic logic [N_W-1:0] clamp_size(input logic [7:0] v, input int maxn);
    logic [31:0] w;
    logic [31:0] m;
    w = {24'd0, v};
    m = maxn;
    if (w == 32'd0) begin
      w = 32'd1;
    end else if (w > m) begin
      w = m;
    end
    return w[N_W-1:0];
  endfunction

  // Seven restoring remainder steps on a narrow remainder.
  function automatic logic [N_W-1:0] mod_chunk(input logic [N_W-1:0] r,
                                               input logic [MOD_STEP-1:0] bits,
                                               input logic [N_W-1:0] n);
    logic [N_W:0]   t;
    logic [N_W-1:0] rr;
    rr = r;
    for (int i = MOD_STEP - 1; i >= 0; i--) begin
      t = {rr, bits[i]};
      if (t >= {1'b0, n}) begin
        t = t - {1'b0, n};
      end
      rr = t[N_W-1:0];
    end
    return rr;
  endfunction

  function automatic logic [COL_W-1:0] col_idx(input logic [31:0] c);
    return c[COL_W-1:0];
  endfunction

  function automatic logic [ROW_W-1:0] row_idx(input logic [31:0] r);
    return r[ROW_W-1:0];
  endfunction

endpackage

[src/pgbf_req_if.sv]
// ----------------------------------------------------------------------------
// pgbf_req_if: input item channel
// Carries grid writes and position queries with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pgbf_req_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [6:0]         sample_row;
  logic [6:0]         sample_col;
  logic signed [31:0] sample_value;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;

  modport source (output valid, kind, sample_row, sample_col, sample_value, pos_x, pos_y,
                  input ready);
  modport sink (input valid, kind, sample_row, sample_col, sample_value, pos_x, pos_y,
                output ready);
endinterface

[src/pgbf_rsp_if.sv]
// ----------------------------------------------------------------------------
// pgbf_rsp_if: result item channel
// Carries the interpolated potential, the force and the clip flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pgbf_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] potential;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic               saturated;

  modport source (output valid, potential, force_x, force_y, saturated, input ready);
  modport sink (input valid, potential, force_x, force_y, saturated, output ready);
endinterface

[src/pgbf_cfg_if.sv]
// ----------------------------------------------------------------------------
// pgbf_cfg_if: configuration write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pgbf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/pgbf_locate.sv]
// ----------------------------------------------------------------------------
// pgbf_locate: position to periodic cell and fraction, one axis
// Maps (pos - origin) * cells_per_unit to a floor cell modulo the grid size,
// its wrapped neighbor and a Q0.16 fraction, in a pipeline of LOC_LAT stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgbf_locate (
  input  logic                          clk,
  input  logic                          en,
  input  pgbf_pkg::word_t               pos,
  input  pgbf_pkg::word_t               origin,
  input  logic [31:0]                   cpu,
  input  logic [pgbf_pkg::N_W-1:0]      n,
  output logic [pgbf_pkg::N_W-1:0]      cell0,
  output logic [pgbf_pkg::N_W-1:0]      cell1,
  output logic [pgbf_pkg::FRAC_W-1:0]   frac
);

  logic signed [32:0]               d;
  logic [32:0]                      mag;
  logic                             neg2;
  logic [48:0]                      pl;
  logic [48:0]                      ph;
  logic                             neg3;
  logic [64:0]                      prod;
  logic                             neg4;
  logic [pgbf_pkg::DIV_W-1:0]       ip;
  logic [pgbf_pkg::FRAC_W-1:0]      frac5;
  logic                             neg5;
  logic [pgbf_pkg::N_W-1:0]         rem    [pgbf_pkg::MOD_STAGES];
  logic [pgbf_pkg::DIV_W-1:0]       dv     [pgbf_pkg::MOD_STAGES];
  logic                             neg_m  [pgbf_pkg::MOD_STAGES];
  logic [pgbf_pkg::FRAC_W-1:0]      frac_m [pgbf_pkg::MOD_STAGES];
  logic [pgbf_pkg::N_W-1:0]         cell11;
  logic [pgbf_pkg::FRAC_W-1:0]      frac11;
  logic [pgbf_pkg::IP_W-1:0]        ip_next;
  logic [pgbf_pkg::FRAC_W-1:0]      frac_next;
  logic [31:0]                      fp_neg;

  // Offset from the origin, magnitude, and the split 33 x 32 product.
  always_ff @(posedge clk) begin
    if (en) begin
      d    <= 33'(pos) - 33'(origin);
      neg2 <= d[32];
      mag  <= d[32] ? 33'(-d) : 33'(d);
      neg3 <= neg2;
      pl   <= mag * cpu[15:0];
      ph   <= mag * cpu[31:16];
      neg4 <= neg3;
      prod <= {16'd0, pl} + {ph, 16'd0};
    end
  end

  // A negative offset with a fraction rounds the integer part up and flips
  // the fraction, so that the cell is the floor.
  always_comb begin
    fp_neg = 32'd0 - prod[31:0];
    if (neg4 && (prod[31:0] != 32'd0)) begin
      ip_next   = prod[64:32] + 1'b1;
      frac_next = fp_neg[31:16];
    end else begin
      ip_next   = prod[64:32];
      frac_next = prod[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ip    <= {{(pgbf_pkg::DIV_W - pgbf_pkg::IP_W){1'b0}}, ip_next};
      frac5 <= frac_next;
      neg5  <= neg4;
    end
  end

  // Remainder by the grid size, MOD_STEP dividend bits per stage.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]    <= pgbf_pkg::mod_chunk('0, ip[pgbf_pkg::DIV_W-1 -: pgbf_pkg::MOD_STEP], n);
      dv[0]     <= ip << pgbf_pkg::MOD_STEP;
      neg_m[0]  <= neg5;
      frac_m[0] <= frac5;
      for (int k = 1; k < pgbf_pkg::MOD_STAGES; k++) begin
        rem[k]    <= pgbf_pkg::mod_chunk(rem[k-1],
                       dv[k-1][pgbf_pkg::DIV_W-1 -: pgbf_pkg::MOD_STEP], n);
        dv[k]     <= dv[k-1] << pgbf_pkg::MOD_STEP;
        neg_m[k]  <= neg_m[k-1];
        frac_m[k] <= frac_m[k-1];
      end
    end
  end

  // Mirror the remainder for negative offsets, then find the wrapped neighbor.
  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_m[pgbf_pkg::MOD_STAGES-1] && (rem[pgbf_pkg::MOD_STAGES-1] != '0)) begin
        cell11 <= n - rem[pgbf_pkg::MOD_STAGES-1];
      end else begin
        cell11 <= rem[pgbf_pkg::MOD_STAGES-1];
      end
      frac11 <= frac_m[pgbf_pkg::MOD_STAGES-1];
      cell0  <= cell11;
      cell1  <= ((cell11 + 1'b1) >= n) ? '0 : cell11 + 1'b1;
      frac   <= frac11;
    end
  end

endmodule

[src/pgbf_grid.sv]
// ----------------------------------------------------------------------------
// pgbf_grid: sample store with four reads per cycle while en is high
// Two identical copies of the grid, one for the lower and one for the upper
// row of a cell, each read at two columns. Writes go to both copies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgbf_grid (
  input  logic                          clk,
  input  logic                          en,
  input  pgbf_pkg::grid_wr_t            wr,
  input  logic [pgbf_pkg::COL_W-1:0]    col0,
  input  logic [pgbf_pkg::COL_W-1:0]    col1,
  input  logic [pgbf_pkg::ROW_W-1:0]    row0,
  input  logic [pgbf_pkg::ROW_W-1:0]    row1,
  output pgbf_pkg::word_t               corner [pgbf_pkg::NUM_CORNERS]
);

  logic [pgbf_pkg::ROW_W-1:0] row_sel [2];
  logic [31:0]                rd0     [2];
  logic [31:0]                rd1     [2];

  assign row_sel[0] = row0;
  assign row_sel[1] = row1;

  // One memory copy per row offset of the cell.
  for (genvar c = 0; c < 2; c++) begin : g_copy
    logic [31:0] mem [pgbf_pkg::MAX_ROWS][pgbf_pkg::MAX_COLS];

    always_ff @(posedge clk) begin
      if (en) begin
        if (wr.valid) begin
          mem[wr.row][wr.col] <= wr.value;
        end
        rd0[c] <= mem[row_sel[c]][col0];
        rd1[c] <= mem[row_sel[c]][col1];
      end
    end
  end

  // Route the read ports to the four corners.
  always_comb begin
    for (int k = 0; k < pgbf_pkg::NUM_CORNERS; k++) begin
      if (pgbf_pkg::CORNER_DY[k]) begin
        corner[k] = pgbf_pkg::CORNER_DX[k] ? rd1[1] : rd0[1];
      end else begin
        corner[k] = pgbf_pkg::CORNER_DX[k] ? rd1[0] : rd0[0];
      end
    end
  end

endmodule

[src/pgbf_interp.sv]
// ----------------------------------------------------------------------------
// pgbf_interp: bilinear potential and scaled negative gradient
// Forms the weights from the fractions, the row blends and slopes, the
// potential, the force scaled by cells per unit, and clips the force to Q16.16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgbf_interp (
  input  logic                          clk,
  input  logic                          en,
  input  pgbf_pkg::word_t               corner [pgbf_pkg::NUM_CORNERS],
  input  logic [pgbf_pkg::FRAC_W-1:0]   fx,
  input  logic [pgbf_pkg::FRAC_W-1:0]   fy,
  input  logic [31:0]                   cpu_x,
  input  logic [31:0]                   cpu_y,
  output pgbf_pkg::result_t             result
);

  logic signed [17:0] ex;
  logic signed [17:0] ey;
  logic signed [17:0] fxs;
  logic signed [17:0] fys;
  pgbf_pkg::word_t    fq [pgbf_pkg::NUM_CORNERS];
  logic signed [32:0] dx0, dx1, dy0, dy1;
  logic signed [49:0] pa0, pa1, pb0, pb1;
  logic signed [50:0] qx0, qx1, qy0, qy1;
  logic signed [17:0] ey15, fy15, ey16, fy16;
  logic signed [50:0] a, b;
  logic signed [51:0] gx, gy;
  logic signed [68:0] ta, tb;
  logic signed [36:0] sx, sy;
  logic signed [69:0] pot_sum;
  pgbf_pkg::word_t    pot18, pot19;
  logic signed [53:0] xl, xh, yl, yh;
  logic signed [54:0] fsx, fsy;
  pgbf_pkg::word_t    clip_x, clip_y;
  logic               sat_x, sat_y;

  // Complementary weights and corner differences.
  always_ff @(posedge clk) begin
    if (en) begin
      ex  <= {1'b0, 17'(17'h10000 - {1'b0, fx})};
      ey  <= {1'b0, 17'(17'h10000 - {1'b0, fy})};
      fxs <= {2'b00, fx};
      fys <= {2'b00, fy};
      for (int k = 0; k < pgbf_pkg::NUM_CORNERS; k++) begin
        fq[k] <= corner[k];
      end
      dx0 <= 33'(corner[pgbf_pkg::C10]) - 33'(corner[pgbf_pkg::C00]);
      dx1 <= 33'(corner[pgbf_pkg::C11]) - 33'(corner[pgbf_pkg::C01]);
      dy0 <= 33'(corner[pgbf_pkg::C01]) - 33'(corner[pgbf_pkg::C00]);
      dy1 <= 33'(corner[pgbf_pkg::C11]) - 33'(corner[pgbf_pkg::C10]);
    end
  end

  // Row blends along x and the slope terms.
  always_ff @(posedge clk) begin
    if (en) begin
      pa0  <= ex * fq[pgbf_pkg::C00];
      pa1  <= fxs * fq[pgbf_pkg::C10];
      pb0  <= ex * fq[pgbf_pkg::C01];
      pb1  <= fxs * fq[pgbf_pkg::C11];
      qx0  <= ey * dx0;
      qx1  <= fys * dx1;
      qy0  <= ex * dy0;
      qy1  <= fxs * dy1;
      ey15 <= ey;
      fy15 <= fys;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a    <= 51'(pa0) + 51'(pa1);
      b    <= 51'(pb0) + 51'(pb1);
      gx   <= 52'(qx0) + 52'(qx1);
      gy   <= 52'(qy0) + 52'(qy1);
      ey16 <= ey15;
      fy16 <= fy15;
    end
  end

  // Blend along y; slopes become Q16.16 and are negated.
  always_ff @(posedge clk) begin
    if (en) begin
      ta <= ey16 * a;
      tb <= fy16 * b;
      sx <= -(37'(gx >>> 16));
      sy <= -(37'(gy >>> 16));
    end
  end

  assign pot_sum = 70'(ta) + 70'(tb);

  // Scale by cells per unit in two 16-bit halves.
  always_ff @(posedge clk) begin
    if (en) begin
      pot18 <= pot_sum[63:32];
      xl    <= sx * $signed({1'b0, cpu_x[15:0]});
      xh    <= sx * $signed({1'b0, cpu_x[31:16]});
      yl    <= sy * $signed({1'b0, cpu_y[15:0]});
      yh    <= sy * $signed({1'b0, cpu_y[31:16]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pot19 <= pot18;
      fsx   <= 55'(xh) + 55'(xl >>> 16);
      fsy   <= 55'(yh) + 55'(yl >>> 16);
    end
  end

  // Clip the force to the signed 32-bit range.
  always_comb begin
    sat_x = 1'b0;
    sat_y = 1'b0;
    if (fsx > 55'sd2147483647) begin
      clip_x = 32'h7FFFFFFF;
      sat_x  = 1'b1;
    end else if (fsx < -55'sd2147483648) begin
      clip_x = 32'h80000000;
      sat_x  = 1'b1;
    end else begin
      clip_x = fsx[31:0];
    end
    if (fsy > 55'sd2147483647) begin
      clip_y = 32'h7FFFFFFF;
      sat_y  = 1'b1;
    end else if (fsy < -55'sd2147483648) begin
      clip_y = 32'h80000000;
      sat_y  = 1'b1;
    end else begin
      clip_y = fsy[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.potential <= pot19;
      result.force_x   <= clip_x;
      result.force_y   <= clip_y;
      result.saturated <= sat_x | sat_y;
    end
  end

endmodule

[src/periodic_grid_bilinear_field_core.sv]
// ----------------------------------------------------------------------------
// periodic_grid_bilinear_field_core: periodic bilinear potential field
// Top level: configuration registers, item pipeline, grid store, output skid.
// ----------------------------------------------------------------------------
// Usage:
//   req carries items. kind 0 writes sample_value at (sample_row, sample_col)
//   of the grid store; kind 1 queries (pos_x, pos_y) and yields one result on
//   rsp: potential, force_x, force_y and the clip flag. A write yields nothing.
//   cfg writes the grid size, origins and cells per unit; it is always ready
//   and is meant to be used while no query is in flight.
//   Throughput is one item per cycle while the skid register is empty. The
//   depth of the query path is set by the five-stage remainder by the grid
//   size and the multiply chain of the interpolation.
//   A write is seen by every query accepted after it.
//   When rsp stalls, a result waits in the output register and the pipeline
//   keeps moving until one more result lands in the skid register; req.ready
//   then drops and the whole pipeline holds until the skid drains.
//   Reset clears the pipeline, the output stage and the registers to their
//   defaults. The grid store is not cleared: every sample that a query reads
//   must have been written first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_grid_bilinear_field_core (
  input logic        clk,
  input logic        rst,
  pgbf_req_if.sink   req,
  pgbf_rsp_if.source rsp,
  pgbf_cfg_if.sink   cfg
);

  logic [7:0]                  grid_cols;
  logic [7:0]                  grid_rows;
  pgbf_pkg::word_t             x_origin;
  pgbf_pkg::word_t             y_origin;
  logic [31:0]                 x_cells_per_unit;
  logic [31:0]                 y_cells_per_unit;
  logic [pgbf_pkg::N_W-1:0]    n_cols;
  logic [pgbf_pkg::N_W-1:0]    n_rows;
  logic                        en;
  logic                        push;
  logic                        qv     [pgbf_pkg::TOTAL_LAT];
  pgbf_pkg::grid_wr_t          wr_pipe [pgbf_pkg::LOC_LAT];
  pgbf_pkg::grid_wr_t          wr_in;
  logic [pgbf_pkg::N_W-1:0]    cx0, cx1, cy0, cy1;
  logic [pgbf_pkg::FRAC_W-1:0] frac_x, frac_y;
  logic [pgbf_pkg::FRAC_W-1:0] fx13, fy13;
  pgbf_pkg::word_t             corner [pgbf_pkg::NUM_CORNERS];
  pgbf_pkg::result_t           res;
  pgbf_pkg::result_t           out_q;
  pgbf_pkg::result_t           skid_q;
  logic                        out_valid;
  logic                        skid_valid;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols        <= 8'd128;
      grid_rows        <= 8'd128;
      x_origin         <= '0;
      y_origin         <= '0;
      x_cells_per_unit <= 32'h0001_0000;
      y_cells_per_unit <= 32'h0001_0000;
    end else if (cfg.valid) begin
      case (cfg.index)
        pgbf_pkg::REG_GRID_COLS: grid_cols        <= cfg.data[7:0];
        pgbf_pkg::REG_GRID_ROWS: grid_rows        <= cfg.data[7:0];
        pgbf_pkg::REG_X_ORIGIN:  x_origin         <= cfg.data;
        pgbf_pkg::REG_Y_ORIGIN:  y_origin         <= cfg.data;
        pgbf_pkg::REG_X_CPU:     x_cells_per_unit <= cfg.data;
        pgbf_pkg::REG_Y_CPU:     y_cells_per_unit <= cfg.data;
        default: ;
      endcase
    end
  end

  assign n_cols = pgbf_pkg::clamp_size(grid_cols, pgbf_pkg::MAX_COLS);
  assign n_rows = pgbf_pkg::clamp_size(grid_rows, pgbf_pkg::MAX_ROWS);

  // The pipeline moves whenever the skid register is empty.
  assign en        = !skid_valid;
  assign req.ready = en;
  assign push      = en && qv[pgbf_pkg::TOTAL_LAT-1];

  // Writes outside the store are dropped at entry.
  always_comb begin
    wr_in.valid = req.valid && (req.kind == pgbf_pkg::KIND_WRITE) &&
                  (32'(req.sample_row) < pgbf_pkg::MAX_ROWS) &&
                  (32'(req.sample_col) < pgbf_pkg::MAX_COLS);
    wr_in.row   = pgbf_pkg::row_idx(32'(req.sample_row));
    wr_in.col   = pgbf_pkg::col_idx(32'(req.sample_col));
    wr_in.value = req.sample_value;
  end

  // Item tracking: query valid bits and the write side band.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pgbf_pkg::TOTAL_LAT; i++) begin
        qv[i] <= 1'b0;
      end
      for (int i = 0; i < pgbf_pkg::LOC_LAT; i++) begin
        wr_pipe[i] <= '0;
      end
    end else if (en) begin
      qv[0] <= req.valid && (req.kind == pgbf_pkg::KIND_QUERY);
      for (int i = 1; i < pgbf_pkg::TOTAL_LAT; i++) begin
        qv[i] <= qv[i-1];
      end
      wr_pipe[0] <= wr_in;
      for (int i = 1; i < pgbf_pkg::LOC_LAT; i++) begin
        wr_pipe[i] <= wr_pipe[i-1];
      end
    end
  end

  pgbf_locate u_locate_x (
    .clk    (clk),
    .en     (en),
    .pos    (req.pos_x),
    .origin (x_origin),
    .cpu    (x_cells_per_unit),
    .n      (n_cols),
    .cell0  (cx0),
    .cell1  (cx1),
    .frac   (frac_x)
  );

  pgbf_locate u_locate_y (
    .clk    (clk),
    .en     (en),
    .pos    (req.pos_y),
    .origin (y_origin),
    .cpu    (y_cells_per_unit),
    .n      (n_rows),
    .cell0  (cy0),
    .cell1  (cy1),
    .frac   (frac_y)
  );

  pgbf_grid u_grid (
    .clk    (clk),
    .en     (en),
    .wr     (wr_pipe[pgbf_pkg::LOC_LAT-1]),
    .col0   (pgbf_pkg::col_idx(32'(cx0))),
    .col1   (pgbf_pkg::col_idx(32'(cx1))),
    .row0   (pgbf_pkg::row_idx(32'(cy0))),
    .row1   (pgbf_pkg::row_idx(32'(cy1))),
    .corner (corner)
  );

  // Fractions are registered once so that they line up with the grid read.
  always_ff @(posedge clk) begin
    if (en) begin
      fx13 <= frac_x;
      fy13 <= frac_y;
    end
  end

  pgbf_interp u_interp (
    .clk    (clk),
    .en     (en),
    .corner (corner),
    .fx     (fx13),
    .fy     (fy13),
    .cpu_x  (x_cells_per_unit),
    .cpu_y  (y_cells_per_unit),
    .result (res)
  );

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || rsp.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || rsp.ready) begin
      if (skid_valid) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= res;
      end
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.potential = out_q.potential;
  assign rsp.force_x   = out_q.force_x;
  assign rsp.force_y   = out_q.force_y;
  assign rsp.saturated = out_q.saturated;

endmodule

[src/pgbf_checker.sv]
// ----------------------------------------------------------------------------
// pgbf_checker: port-level checks for the periodic grid bilinear field core
// Watches the item and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgbf_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_potential,
  input logic [31:0] rsp_force_x,
  input logic [31:0] rsp_force_y,
  input logic        rsp_saturated
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_potential) &&
      $stable(rsp_force_x) && $stable(rsp_force_y) && $stable(rsp_saturated))
    else $error("stalled result changed");

  // Input back-pressure only exists while a result is waiting.
  assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid)
    else $error("input blocked with no result pending");

  // The input side closes only after a result was refused.
  assert property (@(posedge clk) disable iff (rst)
    $fell(req_ready) |-> $past(rsp_valid && !rsp_ready))
    else $error("input closed without an output stall");

  // No result right after reset: the pipeline starts empty.
  assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result present right after reset");

endmodule

bind periodic_grid_bilinear_field_core pgbf_checker u_pgbf_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_potential (rsp.potential),
  .rsp_force_x   (rsp.force_x),
  .rsp_force_y   (rsp.force_y),
  .rsp_saturated (rsp.saturated)
);
